// ===== rtl/cvct_pkg.sv =====
// Shared types and constants for the circumradius variance circle test unit.
// No dependencies; compiled first.
package cvct_pkg;

  // Field widths
  localparam int COORD_W  = 20;
  localparam int DIFF_W   = 21;
  localparam int LEN_W    = 21;
  localparam int CROSS_W  = 43;
  localparam int RADIUS_W = 24;
  localparam int VAR_W    = 46;
  localparam int SUM_W    = 32;
  localparam int SQSUM_W  = 56;
  localparam int CNT_W    = 8;
  localparam int NN_W     = 16;

  // Serial arithmetic unit widths
  localparam int ACC_W    = 88;
  localparam int RES_W    = 64;
  localparam int STEP_W   = 6;
  localparam int SQRT_STEPS = ACC_W / 2;
  localparam int DIV_STEPS  = RES_W;

  localparam logic [VAR_W-1:0]    THR_RESET  = VAR_W'(6400);
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  typedef enum logic [1:0] {
    ALU_MAC,
    ALU_SQRT,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic             clr;
    logic             neg;
    logic [RES_W-1:0] opa;
    logic [RES_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic             busy;
    logic [ACC_W-1:0] acc;
    logic [RES_W-1:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CX1, ST_CX2, ST_CY1, ST_CY2, ST_CZ1, ST_CZ2,
    ST_CS1, ST_CS2, ST_CS3, ST_CSQ,
    ST_LU1, ST_LU2, ST_LU3, ST_LUQ,
    ST_LV1, ST_LV2, ST_LV3, ST_LVQ,
    ST_LW1, ST_LW2, ST_LW3, ST_LWQ,
    ST_NM1, ST_NM2, ST_DIV, ST_ACC,
    ST_VN, ST_VA, ST_VB, ST_VDV,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/cvct_if.sv =====
// Valid/ready channel interfaces for triple input and result output.
// Depends on cvct_pkg.
interface cvct_in_if;
  import cvct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_a_x;
  logic signed [COORD_W-1:0] point_a_y;
  logic signed [COORD_W-1:0] point_a_z;
  logic signed [COORD_W-1:0] point_b_x;
  logic signed [COORD_W-1:0] point_b_y;
  logic signed [COORD_W-1:0] point_b_z;
  logic signed [COORD_W-1:0] point_c_x;
  logic signed [COORD_W-1:0] point_c_y;
  logic signed [COORD_W-1:0] point_c_z;
  logic                      final_triple;

  modport source (output valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
                  point_b_z, point_c_x, point_c_y, point_c_z, final_triple, input ready);
  modport sink   (input valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
                  point_b_z, point_c_x, point_c_y, point_c_z, final_triple, output ready);
endinterface

interface cvct_out_if;
  import cvct_pkg::*;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] radius;
  logic                radius_valid;
  logic                radius_saturated;
  logic                verdict_ready;
  logic [VAR_W-1:0]    variance;
  logic                is_circle;

  modport source (output valid, radius, radius_valid, radius_saturated, verdict_ready,
                  variance, is_circle, input ready);
  modport sink   (input valid, radius, radius_valid, radius_saturated, verdict_ready,
                  variance, is_circle, output ready);
endinterface

// ===== rtl/circumradius_variance_circle_test_unit.sv =====
// A collinear triple skips the edge lengths and the radius division; a final triple
// also computes the variance.
// Throughput: one triple at a time; all multiplies, roots and divides share one bit-serial
// unit, and a multiply stops early at its multiplier's top set bit.
// The result register lets the next triple start while a result waits.
// Reset (rst_n, synchronous): clears sums, count and control; threshold returns to 6400.
module circumradius_variance_circle_test_unit #(
  parameter int MAX_TRIPLES = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cvct_in_if.sink                    in_chan,
  cvct_out_if.source                 out_chan,
  input  logic                       cfg_wr_en,
  input  logic [cvct_pkg::VAR_W-1:0] cfg_wr_data
);
  import cvct_pkg::*;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r, wx_r, wy_r, wz_r;
  logic signed [DIFF_W-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [DIFF_W-1:0] wx_nxt, wy_nxt, wz_nxt;
  logic                     last_r, last_nxt;
  logic [CROSS_W-1:0]       kx_r, ky_r, kz_r, clen_r, kx_nxt, ky_nxt, kz_nxt, clen_nxt;
  logic                     valid_r, valid_nxt;
  logic [LEN_W-1:0]         lu_r, lv_r, lw_r, lu_nxt, lv_nxt, lw_nxt;
  logic [RADIUS_W-1:0]      radius_r, radius_nxt;
  logic                     sat_r, sat_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SQSUM_W-1:0]       sq_r, sq_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [NN_W-1:0]          nn_r, nn_nxt;
  logic [VAR_W-1:0]         var_r, var_nxt;
  logic [VAR_W-1:0]         thr_r;

  logic [RADIUS_W-1:0]      o_radius_r, o_radius_nxt;
  logic                     o_valid_r, o_valid_nxt, o_sat_r, o_sat_nxt;
  logic                     o_last_r, o_last_nxt, o_circle_r, o_circle_nxt;
  logic [VAR_W-1:0]         o_var_r, o_var_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     op_st;
  logic     fin;
  logic     acc_ok;

  logic [DIFF_W-1:0] ux_m, uy_m, uz_m, vx_m, vy_m, vz_m, wx_m, wy_m, wz_m;

  function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] d);
    mag_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  function automatic logic [CROSS_W-1:0] mag_acc(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] t;
    t = v[ACC_W-1] ? (~v + 1'b1) : v;
    return t[CROSS_W-1:0];
  endfunction

  assign ux_m = mag_diff(ux_r);
  assign uy_m = mag_diff(uy_r);
  assign uz_m = mag_diff(uz_r);
  assign vx_m = mag_diff(vx_r);
  assign vy_m = mag_diff(vy_r);
  assign vz_m = mag_diff(vz_r);
  assign wx_m = mag_diff(wx_r);
  assign wy_m = mag_diff(wy_r);
  assign wz_m = mag_diff(wz_r);

  // Shared serial arithmetic unit
  cvct_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      thr_r       <= THR_RESET;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // Working registers and result register
  always_ff @(posedge clk) begin
    ux_r <= ux_nxt;  uy_r <= uy_nxt;  uz_r <= uz_nxt;
    vx_r <= vx_nxt;  vy_r <= vy_nxt;  vz_r <= vz_nxt;
    wx_r <= wx_nxt;  wy_r <= wy_nxt;  wz_r <= wz_nxt;
    last_r     <= last_nxt;
    kx_r       <= kx_nxt;
    ky_r       <= ky_nxt;
    kz_r       <= kz_nxt;
    clen_r     <= clen_nxt;
    valid_r    <= valid_nxt;
    lu_r       <= lu_nxt;
    lv_r       <= lv_nxt;
    lw_r       <= lw_nxt;
    radius_r   <= radius_nxt;
    sat_r      <= sat_nxt;
    nn_r       <= nn_nxt;
    var_r      <= var_nxt;
    o_radius_r <= o_radius_nxt;
    o_valid_r  <= o_valid_nxt;
    o_sat_r    <= o_sat_nxt;
    o_last_r   <= o_last_nxt;
    o_var_r    <= o_var_nxt;
    o_circle_r <= o_circle_nxt;
  end

  assign fin    = launched_r && !alu_rsp.busy;
  assign acc_ok = valid_r && (cnt_r < CNT_W'(MAX_TRIPLES));

  // Sequencer: each step issues one operation to the serial unit and waits for it
  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    out_valid_nxt = out_valid_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;  uz_nxt = uz_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;  vz_nxt = vz_r;
    wx_nxt = wx_r;  wy_nxt = wy_r;  wz_nxt = wz_r;
    last_nxt     = last_r;
    kx_nxt       = kx_r;
    ky_nxt       = ky_r;
    kz_nxt       = kz_r;
    clen_nxt     = clen_r;
    valid_nxt    = valid_r;
    lu_nxt       = lu_r;
    lv_nxt       = lv_r;
    lw_nxt       = lw_r;
    radius_nxt   = radius_r;
    sat_nxt      = sat_r;
    sum_nxt      = sum_r;
    sq_nxt       = sq_r;
    cnt_nxt      = cnt_r;
    nn_nxt       = nn_r;
    var_nxt      = var_r;
    o_radius_nxt = o_radius_r;
    o_valid_nxt  = o_valid_r;
    o_sat_nxt    = o_sat_r;
    o_last_nxt   = o_last_r;
    o_var_nxt    = o_var_r;
    o_circle_nxt = o_circle_r;
    alu_req       = '0;
    alu_req.op    = ALU_MAC;
    op_st         = 1'b0;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          ux_nxt = DIFF_W'($signed(in_chan.point_b_x)) - DIFF_W'($signed(in_chan.point_a_x));
          uy_nxt = DIFF_W'($signed(in_chan.point_b_y)) - DIFF_W'($signed(in_chan.point_a_y));
          uz_nxt = DIFF_W'($signed(in_chan.point_b_z)) - DIFF_W'($signed(in_chan.point_a_z));
          vx_nxt = DIFF_W'($signed(in_chan.point_c_x)) - DIFF_W'($signed(in_chan.point_a_x));
          vy_nxt = DIFF_W'($signed(in_chan.point_c_y)) - DIFF_W'($signed(in_chan.point_a_y));
          vz_nxt = DIFF_W'($signed(in_chan.point_c_z)) - DIFF_W'($signed(in_chan.point_a_z));
          wx_nxt = DIFF_W'($signed(in_chan.point_c_x)) - DIFF_W'($signed(in_chan.point_b_x));
          wy_nxt = DIFF_W'($signed(in_chan.point_c_y)) - DIFF_W'($signed(in_chan.point_b_y));
          wz_nxt = DIFF_W'($signed(in_chan.point_c_z)) - DIFF_W'($signed(in_chan.point_b_z));
          last_nxt   = in_chan.final_triple;
          valid_nxt  = 1'b0;
          radius_nxt = '0;
          sat_nxt    = 1'b0;
          var_nxt    = '0;
          state_nxt  = ST_CX1;
        end
      end
      // cross product AB x AC, one signed product at a time
      ST_CX1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(uy_m); alu_req.opb = RES_W'(vz_m);
        alu_req.neg = uy_r[DIFF_W-1] ^ vz_r[DIFF_W-1];
        if (fin) state_nxt = ST_CX2;
      end
      ST_CX2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(uz_m); alu_req.opb = RES_W'(vy_m);
        alu_req.neg = ~(uz_r[DIFF_W-1] ^ vy_r[DIFF_W-1]);
        if (fin) begin
          kx_nxt    = mag_acc(alu_rsp.acc);
          state_nxt = ST_CY1;
        end
      end
      ST_CY1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(uz_m); alu_req.opb = RES_W'(vx_m);
        alu_req.neg = uz_r[DIFF_W-1] ^ vx_r[DIFF_W-1];
        if (fin) state_nxt = ST_CY2;
      end
      ST_CY2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(ux_m); alu_req.opb = RES_W'(vz_m);
        alu_req.neg = ~(ux_r[DIFF_W-1] ^ vz_r[DIFF_W-1]);
        if (fin) begin
          ky_nxt    = mag_acc(alu_rsp.acc);
          state_nxt = ST_CZ1;
        end
      end
      ST_CZ1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(ux_m); alu_req.opb = RES_W'(vy_m);
        alu_req.neg = ux_r[DIFF_W-1] ^ vy_r[DIFF_W-1];
        if (fin) state_nxt = ST_CZ2;
      end
      ST_CZ2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(uy_m); alu_req.opb = RES_W'(vx_m);
        alu_req.neg = ~(uy_r[DIFF_W-1] ^ vx_r[DIFF_W-1]);
        if (fin) begin
          kz_nxt    = mag_acc(alu_rsp.acc);
          state_nxt = ST_CS1;
        end
      end
      // squared cross length and its root
      ST_CS1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(kx_r); alu_req.opb = RES_W'(kx_r);
        if (fin) state_nxt = ST_CS2;
      end
      ST_CS2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(ky_r); alu_req.opb = RES_W'(ky_r);
        if (fin) state_nxt = ST_CS3;
      end
      ST_CS3: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(kz_r); alu_req.opb = RES_W'(kz_r);
        if (fin) state_nxt = ST_CSQ;
      end
      ST_CSQ: begin
        op_st = 1'b1; alu_req.op = ALU_SQRT;
        if (fin) begin
          clen_nxt  = alu_rsp.res[CROSS_W-1:0];
          valid_nxt = |alu_rsp.acc;
          state_nxt = (|alu_rsp.acc) ? ST_LU1 : ST_ACC;
        end
      end
      // edge lengths
      ST_LU1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(ux_m); alu_req.opb = RES_W'(ux_m);
        if (fin) state_nxt = ST_LU2;
      end
      ST_LU2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(uy_m); alu_req.opb = RES_W'(uy_m);
        if (fin) state_nxt = ST_LU3;
      end
      ST_LU3: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(uz_m); alu_req.opb = RES_W'(uz_m);
        if (fin) state_nxt = ST_LUQ;
      end
      ST_LUQ: begin
        op_st = 1'b1; alu_req.op = ALU_SQRT;
        if (fin) begin
          lu_nxt    = alu_rsp.res[LEN_W-1:0];
          state_nxt = ST_LV1;
        end
      end
      ST_LV1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(vx_m); alu_req.opb = RES_W'(vx_m);
        if (fin) state_nxt = ST_LV2;
      end
      ST_LV2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(vy_m); alu_req.opb = RES_W'(vy_m);
        if (fin) state_nxt = ST_LV3;
      end
      ST_LV3: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(vz_m); alu_req.opb = RES_W'(vz_m);
        if (fin) state_nxt = ST_LVQ;
      end
      ST_LVQ: begin
        op_st = 1'b1; alu_req.op = ALU_SQRT;
        if (fin) begin
          lv_nxt    = alu_rsp.res[LEN_W-1:0];
          state_nxt = ST_LW1;
        end
      end
      ST_LW1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(wx_m); alu_req.opb = RES_W'(wx_m);
        if (fin) state_nxt = ST_LW2;
      end
      ST_LW2: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(wy_m); alu_req.opb = RES_W'(wy_m);
        if (fin) state_nxt = ST_LW3;
      end
      ST_LW3: begin
        op_st = 1'b1;
        alu_req.opa = RES_W'(wz_m); alu_req.opb = RES_W'(wz_m);
        if (fin) state_nxt = ST_LWQ;
      end
      ST_LWQ: begin
        op_st = 1'b1; alu_req.op = ALU_SQRT;
        if (fin) begin
          lw_nxt    = alu_rsp.res[LEN_W-1:0];
          state_nxt = ST_NM1;
        end
      end
      // numerator = product of the three lengths
      ST_NM1: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(lu_r); alu_req.opb = RES_W'(lv_r);
        if (fin) state_nxt = ST_NM2;
      end
      ST_NM2: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(alu_rsp.acc[2*LEN_W-1:0]); alu_req.opb = RES_W'(lw_r);
        if (fin) state_nxt = ST_DIV;
      end
      // radius = numerator / (2 * cross length), clamped to the field
      ST_DIV: begin
        op_st = 1'b1; alu_req.op = ALU_DIV;
        alu_req.opa = RES_W'({clen_r, 1'b0});
        if (fin) begin
          if (|alu_rsp.res[RES_W-1:RADIUS_W]) begin
            radius_nxt = RADIUS_MAX;
            sat_nxt    = 1'b1;
          end else begin
            radius_nxt = alu_rsp.res[RADIUS_W-1:0];
          end
          state_nxt = ST_ACC;
        end
      end
      // running sums of valid radii, while the triple budget lasts
      ST_ACC: begin
        if (acc_ok) begin
          op_st = 1'b1; alu_req.clr = 1'b1;
          alu_req.opa = RES_W'(radius_r); alu_req.opb = RES_W'(radius_r);
          if (fin) begin
            sum_nxt   = sum_r + SUM_W'(radius_r);
            sq_nxt    = sq_r + SQSUM_W'(alu_rsp.acc[2*RADIUS_W-1:0]);
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = last_r ? ST_VN : ST_OUT;
          end
        end else begin
          state_nxt = last_r ? ST_VN : ST_OUT;
        end
      end
      // variance = (n*S2 - S1*S1) / (n*n)
      ST_VN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          op_st = 1'b1; alu_req.clr = 1'b1;
          alu_req.opa = RES_W'(cnt_r); alu_req.opb = RES_W'(cnt_r);
          if (fin) begin
            nn_nxt    = alu_rsp.acc[NN_W-1:0];
            state_nxt = ST_VA;
          end
        end
      end
      ST_VA: begin
        op_st = 1'b1; alu_req.clr = 1'b1;
        alu_req.opa = RES_W'(sq_r); alu_req.opb = RES_W'(cnt_r);
        if (fin) state_nxt = ST_VB;
      end
      ST_VB: begin
        op_st = 1'b1; alu_req.neg = 1'b1;
        alu_req.opa = RES_W'(sum_r); alu_req.opb = RES_W'(sum_r);
        if (fin) state_nxt = ST_VDV;
      end
      ST_VDV: begin
        if (alu_rsp.acc[ACC_W-1]) begin
          state_nxt = ST_OUT;
        end else begin
          op_st = 1'b1; alu_req.op = ALU_DIV;
          alu_req.opa = RES_W'(nn_r);
          if (fin) begin
            var_nxt   = alu_rsp.res[VAR_W-1:0];
            state_nxt = ST_OUT;
          end
        end
      end
      // hand the result to the output register; a final triple also clears the sums and count
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          o_radius_nxt  = radius_r;
          o_valid_nxt   = valid_r;
          o_sat_nxt     = sat_r;
          o_last_nxt    = last_r;
          o_var_nxt     = var_r;
          o_circle_nxt  = last_r && (cnt_r != '0) && (var_r < thr_r);
          if (last_r) begin
            sum_nxt = '0;
            sq_nxt  = '0;
            cnt_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // launch once per step, advance when the unit goes idle
    if (op_st) begin
      if (!launched_r) begin
        alu_req.start = 1'b1;
        launched_nxt  = 1'b1;
      end else if (fin) begin
        launched_nxt = 1'b0;
      end
    end
  end

  assign in_chan.ready             = (state_r == ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.radius           = o_radius_r;
  assign out_chan.radius_valid     = o_valid_r;
  assign out_chan.radius_saturated = o_sat_r;
  assign out_chan.verdict_ready    = o_last_r;
  assign out_chan.variance         = o_var_r;
  assign out_chan.is_circle        = o_circle_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("serial unit started while busy");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TRIPLES))
    else $error("valid count beyond triple budget");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.radius_saturated |->
      out_chan.radius_valid && (out_chan.radius == RADIUS_MAX))
    else $error("saturated radius not clamped");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.radius_valid |->
      (out_chan.radius == '0) && !out_chan.radius_saturated)
    else $error("collinear triple with nonzero radius");

  a_circle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.is_circle |-> out_chan.verdict_ready)
    else $error("circle verdict on a non-final triple");
`endif

endmodule

// ===== rtl/cvct_serial_alu.sv =====
// Bit-serial arithmetic unit: multiply-accumulate, integer square root, division.
// One bit (or one root digit) per cycle. Depends on cvct_pkg.
module cvct_serial_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  cvct_pkg::alu_req_t req_i,
  output cvct_pkg::alu_rsp_t rsp_o
);
  import cvct_pkg::*;

  logic              busy_r, busy_nxt;
  alu_op_t           op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  mc_r, mc_nxt;
  logic [RES_W-1:0]  mp_r, mp_nxt;
  logic [ACC_W-1:0]  src_r, src_nxt;
  logic [RES_W:0]    rem_r, rem_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  logic [RES_W:0]    rem_sh;
  logic [RES_W:0]    trial;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    src_r <= src_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    rem_sh   = '0;
    trial    = '0;

    if (req_i.start) begin
      // load operands; sqrt and divide take their source from the accumulator
      busy_nxt = 1'b1;
      op_nxt   = req_i.op;
      neg_nxt  = req_i.neg;
      mc_nxt   = ACC_W'(req_i.opa);
      mp_nxt   = req_i.opb;
      rem_nxt  = '0;
      res_nxt  = '0;
      if (req_i.clr) begin
        acc_nxt = '0;
      end
      unique case (req_i.op)
        ALU_SQRT: begin
          src_nxt = acc_r;
          cnt_nxt = STEP_W'(SQRT_STEPS - 1);
        end
        ALU_DIV: begin
          src_nxt = {acc_r[RES_W-1:0], (ACC_W-RES_W)'(0)};
          cnt_nxt = STEP_W'(DIV_STEPS - 1);
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        ALU_MAC: begin
          // shift-add, stops once the multiplier runs out of set bits
          if (mp_r == '0) begin
            busy_nxt = 1'b0;
          end else begin
            if (mp_r[0]) begin
              acc_nxt = neg_r ? (acc_r - mc_r) : (acc_r + mc_r);
            end
            mc_nxt = {mc_r[ACC_W-2:0], 1'b0};
            mp_nxt = {1'b0, mp_r[RES_W-1:1]};
          end
        end
        ALU_SQRT: begin
          // restoring root, two source bits per step
          rem_sh = {rem_r[RES_W-2:0], src_r[ACC_W-1 -: 2]};
          trial  = {res_r[RES_W-2:0], 2'b01};
          if (rem_sh >= trial) begin
            rem_nxt = rem_sh - trial;
            res_nxt = {res_r[RES_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            res_nxt = {res_r[RES_W-2:0], 1'b0};
          end
          src_nxt = {src_r[ACC_W-3:0], 2'b00};
          if (cnt_r == '0) busy_nxt = 1'b0;
          else             cnt_nxt  = cnt_r - 1'b1;
        end
        ALU_DIV: begin
          // restoring division, one quotient bit per step
          rem_sh = {rem_r[RES_W-1:0], src_r[ACC_W-1]};
          if (rem_sh >= mc_r[RES_W:0]) begin
            rem_nxt = rem_sh - mc_r[RES_W:0];
            res_nxt = {res_r[RES_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            res_nxt = {res_r[RES_W-2:0], 1'b0};
          end
          src_nxt = {src_r[ACC_W-2:0], 1'b0};
          if (cnt_r == '0) busy_nxt = 1'b0;
          else             cnt_nxt  = cnt_r - 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  assign rsp_o.busy = busy_r;
  assign rsp_o.acc  = acc_r;
  assign rsp_o.res  = res_r;

endmodule
